// ===== hdl/cks_pkg.sv =====
// Shared types and constants for the cross-kernel sharpen stream.
// No dependencies; used by every module of the block.
package cks_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam int WREG_W = 12;
  localparam int ROW_W  = 16;
  localparam int CHAN_W = 3;
  localparam int PIX_W  = 8;

  localparam logic [WREG_W-1:0] WIDTH_RST   = 12'd640;
  localparam logic [ROW_W-1:0]  HEIGHT_RST  = 16'd480;
  localparam logic [CHAN_W-1:0] CHANNEL_RST = 3'd1;

  localparam int KERNEL_GAIN = 5;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW    = 3;
  localparam int FIFO_CW    = 4;

  // per-sample flags carried from the address stage to the kernel stage
  typedef struct packed {
    logic row_nz;
    logic border;
    logic last_row;
    logic last_col;
  } tag_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             run_last;
    logic             frame_end;
  } res_t;

endpackage

// ===== hdl/cks_line_store.sv =====
// Two line stores (row r-1 and row r-2) with registered reads.
// Depends on cks_pkg for the sample width.
module cks_line_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_x,
  input  logic [AW-1:0]          rd_right,
  input  logic                   recent_we,
  input  logic                   older_we,
  input  logic [AW-1:0]          wr_x,
  input  logic [cks_pkg::PIX_W-1:0] recent_wdata,
  input  logic [cks_pkg::PIX_W-1:0] older_wdata,
  output logic [cks_pkg::PIX_W-1:0] centre,
  output logic [cks_pkg::PIX_W-1:0] right,
  output logic [cks_pkg::PIX_W-1:0] up
);

  logic [cks_pkg::PIX_W-1:0] recent_mem [DEPTH];
  logic [cks_pkg::PIX_W-1:0] older_mem  [DEPTH];

  // back-to-back samples never touch the entry being written, so no bypass
  always_ff @(posedge clk) begin
    if (recent_we) begin
      recent_mem[wr_x] <= recent_wdata;
    end
    if (rd_en) begin
      centre <= recent_mem[rd_x];
      right  <= recent_mem[rd_right];
    end
  end

  always_ff @(posedge clk) begin
    if (older_we) begin
      older_mem[wr_x] <= older_wdata;
    end
    if (rd_en) begin
      up <= older_mem[rd_x];
    end
  end

endmodule

// ===== hdl/cks_ctrl.sv =====
// Configuration registers, raster position tracking and the address stage.
// Depends on cks_pkg for register codes, widths and the tag struct.
module cks_ctrl #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4,
  parameter int AW           = 13,
  parameter int LW           = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cks_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_acc,
  input  logic [cks_pkg::PIX_W-1:0]     sample_in,
  output logic [AW-1:0]                 rd_x,
  output logic [AW-1:0]                 rd_right,
  output logic                          s1_valid,
  output cks_pkg::tag_t                 s1_tag,
  output logic [AW-1:0]                 s1_x,
  output logic [cks_pkg::PIX_W-1:0]     s1_down,
  output logic [cks_pkg::CHAN_W-1:0]    eff_ch
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int WCW = (WW > cks_pkg::WREG_W) ? WW : cks_pkg::WREG_W;
  localparam int RW  = cks_pkg::ROW_W;

  logic [cks_pkg::WREG_W-1:0] cfg_width;
  logic [RW-1:0]              cfg_height;
  logic [cks_pkg::CHAN_W-1:0] cfg_chan;
  logic [AW-1:0]              pos;
  logic [RW-1:0]              row;

  logic [WCW-1:0] wext;
  logic [WCW-1:0] w_clamped;
  logic [WW-1:0]  eff_w;
  logic [RW-1:0]  eff_h;
  logic [LW-1:0]  len;
  logic           wrap;
  logic [RW:0]    row_inc;
  logic [RW-1:0]  r0;
  logic [AW-1:0]  x0;
  logic [LW-1:0]  x0_ext;
  logic [LW-1:0]  x_inc;
  logic [RW:0]    r_inc;
  logic [AW-1:0]  pos_next;
  logic [RW-1:0]  row_next;
  cks_pkg::tag_t  tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= cks_pkg::WIDTH_RST;
      cfg_height <= cks_pkg::HEIGHT_RST;
      cfg_chan   <= cks_pkg::CHANNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cks_pkg::REG_IMAGE_WIDTH:   cfg_width  <= cfg_data[cks_pkg::WREG_W-1:0];
        cks_pkg::REG_IMAGE_HEIGHT:  cfg_height <= cfg_data[RW-1:0];
        cks_pkg::REG_CHANNEL_COUNT: cfg_chan   <= cfg_data[cks_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: out-of-range registers are clamped
  always_comb begin
    wext = WCW'(cfg_width);
    if (wext < WCW'(3)) begin
      w_clamped = WCW'(3);
    end else if (wext > WCW'(MAX_WIDTH)) begin
      w_clamped = WCW'(MAX_WIDTH);
    end else begin
      w_clamped = wext;
    end
    eff_w = WW'(w_clamped);

    if (cfg_chan == '0) begin
      eff_ch = cks_pkg::CHAN_W'(1);
    end else if (cfg_chan > cks_pkg::CHAN_W'(MAX_CHANNELS)) begin
      eff_ch = cks_pkg::CHAN_W'(MAX_CHANNELS);
    end else begin
      eff_ch = cfg_chan;
    end

    eff_h = (cfg_height < RW'(3)) ? RW'(3) : cfg_height;
    len   = LW'(eff_w) * LW'(eff_ch);
  end

  // position of this sample; a stale position past the row starts a new row
  always_comb begin
    wrap    = LW'(pos) >= len;
    row_inc = wrap ? ({1'b0, row} + (RW+1)'(1)) : {1'b0, row};
    r0      = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[RW-1:0];
    x0      = wrap ? '0 : pos;
    x0_ext  = LW'(x0);

    x_inc = x0_ext + LW'(1);
    r_inc = {1'b0, r0} + (RW+1)'(1);
    if (x_inc >= len) begin
      pos_next = '0;
      row_next = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[RW-1:0];
    end else begin
      pos_next = AW'(x_inc);
      row_next = r0;
    end

    tag.row_nz   = r0 != '0;
    tag.border   = (r0 == RW'(1)) || (x0_ext < LW'(eff_ch)) ||
                   (x0_ext >= len - LW'(eff_ch));
    tag.last_row = r0 == eff_h - RW'(1);
    tag.last_col = x0_ext == len - LW'(1);

    rd_x     = x0;
    rd_right = AW'(x0_ext + LW'(eff_ch));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
      if (in_acc) begin
        pos <= pos_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tag  <= tag;
      s1_x    <= x0;
      s1_down <= sample_in;
    end
  end

`ifndef ASSERT_OFF
  a_x_in_row: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (x0_ext < len && r0 < eff_h))
    else $error("sample position outside the image");

  a_stage_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (s1_valid && s1_x == $past(x0)))
    else $error("accepted beat did not reach the kernel stage");
`endif

endmodule

// ===== hdl/cks_kernel.sv =====
// Kernel stage: left-neighbour window, cross mask with saturation, result beats.
// Depends on cks_pkg for the tag and result structs.
module cks_kernel #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  cks_pkg::tag_t              s1_tag,
  input  logic [cks_pkg::PIX_W-1:0]  s1_down,
  input  logic [cks_pkg::PIX_W-1:0]  centre,
  input  logic [cks_pkg::PIX_W-1:0]  right,
  input  logic [cks_pkg::PIX_W-1:0]  up,
  input  logic [cks_pkg::CHAN_W-1:0] eff_ch,
  output logic [1:0]                 push_cnt,
  output cks_pkg::res_t              res0,
  output cks_pkg::res_t              res1
);

  localparam int SW = 11;

  // centre-row delay line; tap eff_ch-1 is the same channel one pixel left
  logic [cks_pkg::PIX_W-1:0] win [MAX_CHANNELS];
  logic [cks_pkg::PIX_W-1:0] left;
  logic [SW-1:0]             gain_sum;
  logic [SW-1:0]             nbr_sum;
  logic [SW-1:0]             diff;
  logic [cks_pkg::PIX_W-1:0] sharp;

  always_comb begin
    left = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (cks_pkg::CHAN_W'(k + 1) == eff_ch) begin
        left = win[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        win[k] <= '0;
      end
    end else if (s1_valid && s1_tag.row_nz) begin
      for (int k = MAX_CHANNELS - 1; k > 0; k--) begin
        if (cks_pkg::CHAN_W'(k) < eff_ch) begin
          win[k] <= win[k-1];
        end
      end
      win[0] <= centre;
    end
  end

  always_comb begin
    gain_sum = SW'(centre) * SW'(cks_pkg::KERNEL_GAIN);
    nbr_sum  = SW'(left) + SW'(right) + SW'(up) + SW'(s1_down);
    diff     = gain_sum - nbr_sum;
    if (gain_sum < nbr_sum) begin
      sharp = '0;
    end else if (diff > SW'(255)) begin
      sharp = '1;
    end else begin
      sharp = diff[cks_pkg::PIX_W-1:0];
    end

    res0.pixel     = s1_tag.border ? '0 : sharp;
    res0.run_last  = !s1_tag.last_row;
    res0.frame_end = 1'b0;
    // last row also emits its own border result
    res1.pixel     = '0;
    res1.run_last  = 1'b1;
    res1.frame_end = s1_tag.last_col;

    if (!s1_valid || !s1_tag.row_nz) begin
      push_cnt = 2'd0;
    end else if (s1_tag.last_row) begin
      push_cnt = 2'd2;
    end else begin
      push_cnt = 2'd1;
    end
  end

endmodule

// ===== hdl/cks_out_fifo.sv =====
// Result queue taking up to two beats a cycle, with input-side flow control.
// Depends on cks_pkg for the result struct and queue sizes.
module cks_out_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                push_cnt,
  input  cks_pkg::res_t             res0,
  input  cks_pkg::res_t             res1,
  input  logic                      pending,
  output logic                      room,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [cks_pkg::PIX_W-1:0] pixel_out,
  output logic                      run_last,
  output logic                      frame_end
);

  localparam int PW = cks_pkg::FIFO_PW;
  localparam int CW = cks_pkg::FIFO_CW;

  cks_pkg::res_t  q [cks_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           pop;
  cks_pkg::res_t  head;
  logic [CW:0]    need;

  assign pop       = out_valid && !out_stall;
  assign out_valid = count != '0;
  assign head      = q[rd_ptr];
  assign pixel_out = head.pixel;
  assign run_last  = head.run_last;
  assign frame_end = head.frame_end;

  // reserve two beats for the sample in the kernel stage and two for a new one
  assign need = (CW+1)'(count) + (pending ? (CW+1)'(2) : '0) + (CW+1)'(2);
  assign room = need <= (CW+1)'(cks_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q[wr_ptr] <= res0;
    end
    if (push_cnt == 2'd2) begin
      q[wr_ptr + PW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push_cnt) - CW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(count) + (CW+1)'(push_cnt) <= (CW+1)'(cks_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CW'($past(push_cnt)) - CW'($past(pop)))
    else $error("result queue count out of step");
`endif

endmodule

// ===== hdl/cross_kernel_sharpen_stream_core.sv =====
// Top level of the cross-kernel sharpen stream.
// Instantiates cks_ctrl, cks_line_store, cks_kernel and cks_out_fifo; uses cks_pkg.
//
// Usage:
//  - Input channel (in_valid/in_stall/sample_in): 8-bit samples in raster
//    order, channels interleaved. One beat per clock is taken while in_stall is low.
//  - Output channel (out_valid/out_stall/pixel_out/run_last/frame_end): the
//    sample of row r, column x yields the sharpened result of (r-1, x);
//    row 0 yields nothing, the last row yields two beats per sample (the row
//    above, then its own border 0). Border pixels come out as 0.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): 0 width,
//    1 height, 2 channel count; write only while the stream is idle.
//  - Result path: input beat -> kernel-stage registers -> result queue -> out_valid.
//  - Throughput: one sample per clock while in_stall is low, set by the single
//    read/write pass on each line store; on the last row the output side carries
//    two beats per sample, so in_stall can hold the input back there.
//  - Reset: position, window and queue clear; the line stores are not cleared
//    and rows are only used once they have been written.
//  - A stalled receiver backs up the 8-beat result queue; in_stall rises once
//    it lacks room for the beats of the sample in flight plus one more sample.
module cross_kernel_sharpen_stream_core #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cks_pkg::PIX_W-1:0]      sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cks_pkg::PIX_W-1:0]      pixel_out,
  output logic                           run_last,
  output logic                           frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cks_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int LW         = $clog2(LINE_DEPTH + 1);

  logic                       in_acc;
  logic                       room;
  logic [AW-1:0]              rd_x;
  logic [AW-1:0]              rd_right;
  logic                       s1_valid;
  cks_pkg::tag_t              s1_tag;
  logic [AW-1:0]              s1_x;
  logic [cks_pkg::PIX_W-1:0]  s1_down;
  logic [cks_pkg::CHAN_W-1:0] eff_ch;
  logic [cks_pkg::PIX_W-1:0]  centre;
  logic [cks_pkg::PIX_W-1:0]  right;
  logic [cks_pkg::PIX_W-1:0]  up;
  logic [1:0]                 push_cnt;
  cks_pkg::res_t              res0;
  cks_pkg::res_t              res1;

  assign in_stall  = rst || !room;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = !rst;

  cks_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW),
    .LW           (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_acc    (in_acc),
    .sample_in (sample_in),
    .rd_x      (rd_x),
    .rd_right  (rd_right),
    .s1_valid  (s1_valid),
    .s1_tag    (s1_tag),
    .s1_x      (s1_x),
    .s1_down   (s1_down),
    .eff_ch    (eff_ch)
  );

  cks_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_lines (
    .clk          (clk),
    .rd_en        (in_acc),
    .rd_x         (rd_x),
    .rd_right     (rd_right),
    .recent_we    (s1_valid),
    .older_we     (s1_valid && s1_tag.row_nz),
    .wr_x         (s1_x),
    .recent_wdata (s1_down),
    .older_wdata  (centre),
    .centre       (centre),
    .right        (right),
    .up           (up)
  );

  cks_kernel #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_kernel (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_tag   (s1_tag),
    .s1_down  (s1_down),
    .centre   (centre),
    .right    (right),
    .up       (up),
    .eff_ch   (eff_ch),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  cks_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1),
    .pending   (s1_valid),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .run_last  (run_last),
    .frame_end (frame_end)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for cross_kernel_sharpen_stream_core: streams frames,
// predicts the sharpened output beats and compares them as they leave the block.
// Depends on cks_pkg and the block's RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W       = 2048;
  localparam int MAX_CH      = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [cks_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [cks_pkg::PIX_W-1:0]      sample_in = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [cks_pkg::PIX_W-1:0]      pixel_out;
  logic                           run_last;
  logic                           frame_end;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [cks_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cks_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  cross_kernel_sharpen_stream_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .run_last  (run_last),
    .frame_end (frame_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and line buffers
  bit [cks_pkg::WREG_W-1:0] width_reg  = cks_pkg::WIDTH_RST;
  bit [cks_pkg::ROW_W-1:0]  height_reg = cks_pkg::HEIGHT_RST;
  bit [cks_pkg::CHAN_W-1:0] chan_reg   = cks_pkg::CHANNEL_RST;
  bit [cks_pkg::PIX_W-1:0]  upper_row_mem  [0:MAX_W*MAX_CH-1];
  bit [cks_pkg::PIX_W-1:0]  center_row_mem [0:MAX_W*MAX_CH-1];
  bit [cks_pkg::PIX_W-1:0]  left_taps [0:3*MAX_CH-1];
  int row_idx = 0;
  int col_idx = 0;

  logic [cks_pkg::PIX_W-1:0] pending_samples[$];
  cks_pkg::res_t             results_due[$];
  int outstanding = 0;
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  bit hold_drain = 1'b0;

  function automatic void frame_geometry(output int ch, output int len, output int h);
    int w;
    w   = (width_reg < 3) ? 3 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    ch  = (chan_reg < 1) ? 1 : (chan_reg > MAX_CH) ? MAX_CH : int'(chan_reg);
    h   = (height_reg < 3) ? 3 : int'(height_reg);
    len = w * ch;
  endfunction

  // advance the shadow by one accepted sample and queue the beats it causes
  task automatic sharpen_sample(input logic [cks_pkg::PIX_W-1:0] below);
    int ch, len, h, x, r, k, acc;
    bit [cks_pkg::PIX_W-1:0] above, mid, lft, rgt;
    cks_pkg::res_t beat;
    frame_geometry(ch, len, h);
    if (col_idx >= len) begin
      col_idx = 0;
      row_idx++;
    end
    if (row_idx >= h) row_idx = 0;
    x = col_idx;
    r = row_idx;
    if (r != 0) begin
      above = upper_row_mem[x];
      mid   = center_row_mem[x];
      rgt   = (x + ch < len) ? center_row_mem[x + ch] : '0;
      lft   = left_taps[ch - 1];
      for (k = ch - 1; k > 0; k--) left_taps[k] = left_taps[k - 1];
      left_taps[0] = mid;
      acc = 0;
      // row r emits pixel row r-1, so r == 1 means the top border
      if (r != 1 && x >= ch && x < len - ch) begin
        acc = cks_pkg::KERNEL_GAIN * int'(mid) - int'(lft) - int'(rgt)
              - int'(above) - int'(below);
        if (acc < 0) acc = 0;
        else if (acc > 255) acc = 255;
      end
      beat.pixel     = acc[cks_pkg::PIX_W-1:0];
      beat.run_last  = (r != h - 1);
      beat.frame_end = 1'b0;
      results_due.push_back(beat);
      if (r == h - 1) begin
        beat.pixel     = '0;
        beat.run_last  = 1'b1;
        beat.frame_end = (x == len - 1);
        results_due.push_back(beat);
      end
      upper_row_mem[x] = mid;
    end
    center_row_mem[x] = below;
    col_idx = x + 1;
    if (col_idx >= len) begin
      col_idx = 0;
      row_idx = (r + 1 >= h) ? 0 : r + 1;
    end
  endtask

  function automatic int samples_to_frame_end();
    int ch, len, h, r, s;
    frame_geometry(ch, len, h);
    r = row_idx;
    s = col_idx;
    if (s >= len) begin
      s = 0;
      r++;
    end
    if (r >= h) r = 0;
    if (r == 0 && s == 0) return 0;
    return (h - 1 - r) * len + (len - s);
  endfunction

  function automatic logic [cks_pkg::PIX_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return cks_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic [cks_pkg::PIX_W-1:0] s);
    pending_samples.push_back(s);
    outstanding++;
  endtask

  task automatic push_samples(input int n);
    repeat (n) push_sample(pick_sample());
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (outstanding != 0 || results_due.size() != 0);
    // row-0 samples cause no beat but may still be in the pipe
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cks_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cks_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cks_pkg::REG_IMAGE_WIDTH:   width_reg  = val[cks_pkg::WREG_W-1:0];
      cks_pkg::REG_IMAGE_HEIGHT:  height_reg = val[cks_pkg::ROW_W-1:0];
      cks_pkg::REG_CHANNEL_COUNT: chan_reg   = val[cks_pkg::CHAN_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one frame of random geometry; some frames get cut short by a mid-frame shrink
  task automatic random_frame(inout int count);
    int ch, len, h, total, tail;
    write_reg(cks_pkg::REG_IMAGE_WIDTH, {4'($urandom), 12'($urandom_range(7))});
    write_reg(cks_pkg::REG_IMAGE_HEIGHT, 16'($urandom_range(5)));
    write_reg(cks_pkg::REG_CHANNEL_COUNT, {13'($urandom), 3'($urandom_range(7))});
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 16'($urandom));
    frame_geometry(ch, len, h);
    total = len * h;
    if ($urandom_range(2) == 0) begin
      total = $urandom_range(total - 1, 1);
      push_samples(total);
      wait_idle();
      // only shrink, so every line buffer entry read has been written
      if ($urandom_range(1)) begin
        write_reg(cks_pkg::REG_IMAGE_WIDTH, 16'($urandom_range(len / ch)));
      end else begin
        write_reg(cks_pkg::REG_IMAGE_HEIGHT, 16'($urandom_range(row_idx)));
      end
      tail = samples_to_frame_end();
      push_samples(tail);
      total += tail;
    end else begin
      push_samples(total);
    end
    count += total;
    wait_idle();
  endtask

  task automatic random_phase(input int gap, input int stall, input int target);
    int n;
    n = 0;
    gap_pct   = gap;
    stall_pct = stall;
    while (n < target) random_frame(n);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sharpen_sample(sample_in);
        outstanding--;
      end
      if (hold_drain && results_due.size() == 0) hold_drain = 1'b0;
      if (in_valid && in_stall) begin
        // stalled beat stays put
      end else if (pending_samples.size() != 0 && !hold_drain &&
                   $urandom_range(99) >= gap_pct) begin
        in_valid  <= 1'b1;
        sample_in <= pending_samples.pop_front();
        if ($urandom_range(149) == 0) hold_drain = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    cks_pkg::res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got pixel %0d run_last %0b %s %0b",
                   $time, pixel_out, run_last, "frame_end", frame_end);
        end else begin
          want = results_due.pop_front();
          if (pixel_out !== want.pixel) begin
            errors++;
            $display("%0t: pixel_out expected %0d got %0d", $time, want.pixel, pixel_out);
          end
          if (run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b got %0b", $time, want.run_last, run_last);
          end
          if (frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
                     frame_end);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // undersized registers clamp to a 3x3 single-channel frame
    write_reg(cks_pkg::REG_IMAGE_WIDTH, 16'h0000);
    write_reg(cks_pkg::REG_IMAGE_HEIGHT, 16'h0001);
    write_reg(cks_pkg::REG_CHANNEL_COUNT, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    // bright center on black: saturates high
    for (i = 0; i < 9; i++) push_sample((i == 4) ? 8'hFF : 8'h00);
    wait_idle();
    // dark center on white: saturates low; upper width bits are ignored
    write_reg(cks_pkg::REG_IMAGE_WIDTH, 16'hF002);
    write_reg(cks_pkg::REG_IMAGE_HEIGHT, 16'h0002);
    for (i = 0; i < 9; i++) push_sample((i == 4) ? 8'h00 : 8'hFF);
    wait_idle();

    random_phase(0, 0, 70);
    random_phase(56, 0, 70);
    random_phase(0, 56, 70);
    random_phase(38, 38, 70);

    // oversized width and height, then shrink mid-frame back to small sizes
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(cks_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(cks_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(cks_pkg::REG_CHANNEL_COUNT, 16'h0001);
    push_samples(40);
    wait_idle();
    write_reg(cks_pkg::REG_IMAGE_WIDTH, 16'd5);
    push_samples(17);
    wait_idle();
    // current row is now past the height, so the frame restarts at row 0
    write_reg(cks_pkg::REG_IMAGE_HEIGHT, 16'd4);
    push_samples(samples_to_frame_end());
    wait_idle();

    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cks_pkg.sv
hdl/cks_line_store.sv
hdl/cks_ctrl.sv
hdl/cks_kernel.sv
hdl/cks_out_fifo.sv
hdl/cross_kernel_sharpen_stream_core.sv
bench/tb_top.sv
